@@ rtl/mpba_pkg.sv @@
package mpba_pkg;

   localparam int NUM_POOLS_DEF     = 4;
   localparam int BUFS_PER_POOL_DEF = 16;

   // Field widths fixed by the register map and the request/response format
   localparam int CFG_POOLS     = 4;
   localparam int SIZE_W        = 16;
   localparam int SLOT_W        = 4;
   localparam int POOL_ID_W     = 2;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 3;
   localparam int POOLS_FIELD_W = 3;
   localparam int COUNT_FIELD_W = 5;
   localparam int COUNTS_W      = 20;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 5;
   localparam int REG_INDEX_W   = 3;

   localparam logic [SIZE_W-1:0] MAX_REQUEST_RESET = 16'd2048;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_QUERY = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_TOO_LARGE    = 3'd1,
      ST_NO_BUFFER    = 3'd2,
      ST_BAD_HANDLE   = 3'd3,
      ST_ALREADY_FREE = 3'd4
   } status_type;

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_POOLS_IN_USE = 3'd0,
      REG_POOL0_SIZE   = 3'd1,
      REG_POOL1_SIZE   = 3'd2,
      REG_POOL2_SIZE   = 3'd3,
      REG_POOL3_SIZE   = 3'd4,
      REG_POOL_COUNTS  = 3'd5,
      REG_MAX_REQUEST  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic              pop;
      logic              push;
      logic [SLOT_W-1:0] push_slot;
   } pool_ctl_type;

   typedef struct packed {
      logic              has_free;
      logic [SLOT_W-1:0] head_slot;
   } pool_sts_type;

endpackage

@@ rtl/multi_pool_buffer_allocator.sv @@
// Packet buffer allocator with up to NUM_POOLS size-class pools, each a FIFO
// free list of BUFS_PER_POOL slots.
// Request channel (req_*): command, request size and a handle (pool, slot).
// Allocate pops the head slot of the first set-up pool that fits and has a
// free buffer; free checks the handle and appends the slot to its pool's
// tail; query returns the pool's buffer size.
// Response channel (rsp_*): one response per request, in order.
// Config port: APB-style, one register per 4 bytes; any write to a defined
// register rebuilds every pool as full with slots in ascending order.
// Path: an accepted request passes the input register, then the result
// register, where its response is held valid. Throughput: one request per
// cycle while rsp_ready keeps the response moving; the pool select, head pop
// and tail append all finish in the execute step, and each pool's free list
// memory is read ahead at the next head position.
// Reset: no pools set up, every count zero, max_request 2048; the first
// request can be taken right after reset.
// Stall: when rsp_ready is low the response holds, one more request waits in
// the input register, and req_ready drops until the response is taken.
module multi_pool_buffer_allocator import mpba_pkg::*; #(
   parameter int NUM_POOLS     = NUM_POOLS_DEF,
   parameter int BUFS_PER_POOL = BUFS_PER_POOL_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [SIZE_W-1:0]     req_request_size,
   input  logic                  req_handle_valid,
   input  logic [POOL_ID_W-1:0]  req_target_pool,
   input  logic [SLOT_W-1:0]     req_target_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [POOL_ID_W-1:0]  rsp_grant_pool,
   output logic [SLOT_W-1:0]     rsp_grant_slot,
   output logic [SIZE_W-1:0]     rsp_buffer_size,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NP_W       = $clog2(NUM_POOLS + 1);
   localparam int CNT_W      = $clog2(BUFS_PER_POOL + 1);
   localparam int SEL_W      = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int MARK_SLOTS = (BUFS_PER_POOL < (1 << SLOT_W)) ? BUFS_PER_POOL
                                                              : (1 << SLOT_W);

   // Configuration
   logic [NP_W-1:0]                     np;
   logic [CFG_POOLS-1:0][SIZE_W-1:0]    cfg_size;
   logic [SIZE_W-1:0]                   max_request;
   logic [NUM_POOLS-1:0][CNT_W-1:0]     caps;
   logic                                rebuild;
   logic [SIZE_W-1:0]                   psize [NUM_POOLS];

   // Input register
   logic                  in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic                  hv_ff;
   logic [POOL_ID_W-1:0]  tp_ff;
   logic [SLOT_W-1:0]     ts_ff;

   // Result register
   logic                  out_valid_ff, out_valid_in;
   status_type            status_ff;
   logic [POOL_ID_W-1:0]  gp_ff;
   logic [SLOT_W-1:0]     gs_ff;
   logic [SIZE_W-1:0]     bsz_ff;

   // Allocated marks
   logic [MARK_SLOTS-1:0] mark_ff [NUM_POOLS];
   logic [MARK_SLOTS-1:0] mark_in [NUM_POOLS];

   pool_ctl_type          ctl [NUM_POOLS];
   pool_sts_type          sts [NUM_POOLS];

   logic                  req_accept, advance;
   logic [SIZE_W-1:0]     limit;
   logic                  found;
   logic [SEL_W-1:0]      sel;
   logic [SLOT_W-1:0]     sel_slot;
   logic [SIZE_W-1:0]     sel_size;
   logic                  in_range;
   logic [CNT_W-1:0]      tgt_cap;
   logic [SIZE_W-1:0]     tgt_size;
   logic                  tgt_mark;
   logic                  handle_ok;
   logic                  alloc_go, free_go;
   status_type            status_c;
   logic [POOL_ID_W-1:0]  gp_c;
   logic [SLOT_W-1:0]     gs_c;
   logic [SIZE_W-1:0]     bsz_c;

   mpba_csr #(
      .NUM_POOLS     (NUM_POOLS),
      .BUFS_PER_POOL (BUFS_PER_POOL)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .np          (np),
      .pool_size   (cfg_size),
      .max_request (max_request),
      .caps        (caps),
      .rebuild     (rebuild)
   );

   for (genvar p = 0; p < NUM_POOLS; p++) begin : g_pool
      if (p < CFG_POOLS) begin : g_sz
         assign psize[p] = cfg_size[p];
      end else begin : g_nosz
         assign psize[p] = '0;
      end

      assign ctl[p].pop       = advance && alloc_go && (sel == SEL_W'(p));
      assign ctl[p].push      = advance && free_go && (int'(tp_ff) == p);
      assign ctl[p].push_slot = ts_ff;

      mpba_pool #(
         .BUFS_PER_POOL (BUFS_PER_POOL)
      ) u_pool (
         .clock   (clock),
         .reset   (reset),
         .rebuild (rebuild),
         .cap     (caps[p]),
         .ctl     (ctl[p]),
         .sts     (sts[p])
      );
   end

   // Handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_command;
         size_ff <= req_request_size;
         hv_ff   <= req_handle_valid;
         tp_ff   <= req_target_pool;
         ts_ff   <= req_target_slot;
      end
      if (advance) begin
         status_ff <= status_c;
         gp_ff     <= gp_c;
         gs_ff     <= gs_c;
         bsz_ff    <= bsz_c;
      end
   end

   // Execute
   always_comb begin
      limit = max_request;
      for (int p = 0; p < NUM_POOLS; p++) begin
         if (p < int'(np) && psize[p] > limit) begin
            limit = psize[p];
         end
      end

      // first fit in ascending pool order
      found    = 1'b0;
      sel      = '0;
      sel_slot = '0;
      sel_size = '0;
      for (int p = 0; p < NUM_POOLS; p++) begin
         if (!found && p < int'(np) && size_ff <= psize[p] && sts[p].has_free) begin
            found    = 1'b1;
            sel      = SEL_W'(p);
            sel_slot = sts[p].head_slot;
            sel_size = psize[p];
         end
      end

      in_range = 1'b0;
      tgt_cap  = '0;
      tgt_size = '0;
      tgt_mark = 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) begin
         if (int'(tp_ff) == p) begin
            in_range = (p < int'(np));
            tgt_cap  = caps[p];
            tgt_size = psize[p];
            for (int s = 0; s < MARK_SLOTS; s++) begin
               if (int'(ts_ff) == s) begin
                  tgt_mark = mark_ff[p][s];
               end
            end
         end
      end
      handle_ok = hv_ff && in_range && (int'(ts_ff) < int'(tgt_cap));

      status_c = ST_OK;
      gp_c     = '0;
      gs_c     = '0;
      bsz_c    = '0;
      alloc_go = 1'b0;
      free_go  = 1'b0;
      case (cmd_ff)
         CMD_ALLOC: begin
            if (size_ff > limit) begin
               status_c = ST_TOO_LARGE;
            end else if (!found) begin
               status_c = ST_NO_BUFFER;
            end else begin
               alloc_go = 1'b1;
               gp_c     = POOL_ID_W'(sel);
               gs_c     = sel_slot;
               bsz_c    = sel_size;
            end
         end
         CMD_FREE: begin
            if (!handle_ok) begin
               status_c = ST_BAD_HANDLE;
            end else if (!tgt_mark) begin
               status_c = ST_ALREADY_FREE;
            end else begin
               free_go = 1'b1;
            end
         end
         CMD_QUERY: begin
            if (!hv_ff) begin
               status_c = ST_OK;
            end else if (!handle_ok) begin
               status_c = ST_BAD_HANDLE;
            end else begin
               bsz_c = tgt_size;
            end
         end
         default: begin
            status_c = ST_OK;
         end
      endcase
   end

   // Set the mark of a granted slot, drop it on a good free
   always_comb begin
      for (int p = 0; p < NUM_POOLS; p++) begin
         mark_in[p] = mark_ff[p];
         for (int s = 0; s < MARK_SLOTS; s++) begin
            if (advance && alloc_go && int'(sel) == p && int'(sel_slot) == s) begin
               mark_in[p][s] = 1'b1;
            end
            if (advance && free_go && int'(tp_ff) == p && int'(ts_ff) == s) begin
               mark_in[p][s] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
         if (reset || rebuild) begin
            mark_ff[p] <= '0;
         end else begin
            mark_ff[p] <= mark_in[p];
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_grant_pool  = gp_ff;
   assign rsp_grant_slot  = gs_ff;
   assign rsp_buffer_size = bsz_ff;

endmodule

@@ rtl/mpba_ram.sv @@
module mpba_ram import mpba_pkg::*; #(
   parameter int WIDTH = SLOT_W,
   parameter int DEPTH = BUFS_PER_POOL_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/mpba_pool.sv @@
module mpba_pool import mpba_pkg::*; #(
   parameter int BUFS_PER_POOL = BUFS_PER_POOL_DEF,
   localparam int PTR_W = (BUFS_PER_POOL > 1) ? $clog2(BUFS_PER_POOL) : 1,
   localparam int CNT_W = $clog2(BUFS_PER_POOL + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rebuild,
   input  logic [CNT_W-1:0] cap,
   input  pool_ctl_type     ctl,
   output pool_sts_type     sts
);

   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(BUFS_PER_POOL - 1);
   localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(BUFS_PER_POOL);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFS_PER_POOL);

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  wcount_ff, wcount_in;
   logic              fwd_valid_ff, fwd_valid_in;
   logic [SLOT_W-1:0] fwd_slot_ff;

   logic [CNT_W:0]    tail_sum, lag_sum, lag;
   logic [PTR_W-1:0]  tail;
   logic              written, we;
   logic [SLOT_W-1:0] rdata;

   // Ring position of the next free entry to append
   assign tail_sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
   assign tail     = (tail_sum >= DEPTH_EXT) ? PTR_W'(tail_sum - DEPTH_EXT) : PTR_W'(tail_sum);

   // Appends since rebuild fill the ring contiguously from position cap;
   // an entry outside that run still holds its own position as slot index.
   assign lag_sum = (CNT_W + 1)'(head_ff) + DEPTH_EXT - (CNT_W + 1)'(cap);
   assign lag     = (lag_sum >= DEPTH_EXT) ? lag_sum - DEPTH_EXT : lag_sum;
   assign written = lag < (CNT_W + 1)'(wcount_ff);

   assign we = ctl.push && !rebuild;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      wcount_in = wcount_ff;
      if (rebuild) begin
         head_in   = '0;
         count_in  = cap;
         wcount_in = '0;
      end else if (ctl.pop) begin
         head_in  = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end else if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
         if (wcount_ff != DEPTH_CNT) begin
            wcount_in = wcount_ff + CNT_W'(1);
         end
      end
   end

   // Bypass an append that lands on the entry being read this cycle
   assign fwd_valid_in = we && (tail == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         wcount_ff    <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         wcount_ff    <= wcount_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_slot_ff <= ctl.push_slot;
   end

   mpba_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (BUFS_PER_POOL)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (tail),
      .wdata (ctl.push_slot),
      .raddr (head_in),
      .rdata (rdata)
   );

   assign sts.has_free  = (count_ff != '0);
   assign sts.head_slot = !written     ? SLOT_W'(head_ff) :
                          fwd_valid_ff ? fwd_slot_ff      : rdata;

endmodule

@@ rtl/mpba_csr.sv @@
module mpba_csr import mpba_pkg::*; #(
   parameter int NUM_POOLS     = NUM_POOLS_DEF,
   parameter int BUFS_PER_POOL = BUFS_PER_POOL_DEF,
   localparam int NP_W  = $clog2(NUM_POOLS + 1),
   localparam int CNT_W = $clog2(BUFS_PER_POOL + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [CSR_ADDR_W-1:0]                paddr,
   input  logic [CSR_DATA_W-1:0]                pwdata,
   output logic [CSR_DATA_W-1:0]                prdata,
   output logic                                 pready,
   output logic [NP_W-1:0]                      np,
   output logic [CFG_POOLS-1:0][SIZE_W-1:0]     pool_size,
   output logic [SIZE_W-1:0]                    max_request,
   output logic [NUM_POOLS-1:0][CNT_W-1:0]      caps,
   output logic                                 rebuild
);

   logic [POOLS_FIELD_W-1:0]            pools_ff, pools_in;
   logic [CFG_POOLS-1:0][SIZE_W-1:0]    size_ff, size_in;
   logic [COUNTS_W-1:0]                 counts_ff, counts_in;
   logic [SIZE_W-1:0]                   max_ff, max_in;
   logic                                rebuild_ff, rebuild_in;
   logic                                wr;
   logic [REG_INDEX_W-1:0]              idx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      pools_in   = pools_ff;
      size_in    = size_ff;
      counts_in  = counts_ff;
      max_in     = max_ff;
      rebuild_in = 1'b0;
      if (wr) begin
         rebuild_in = 1'b1;
         case (idx)
            REG_POOLS_IN_USE: pools_in   = pwdata[POOLS_FIELD_W-1:0];
            REG_POOL0_SIZE:   size_in[0] = pwdata[SIZE_W-1:0];
            REG_POOL1_SIZE:   size_in[1] = pwdata[SIZE_W-1:0];
            REG_POOL2_SIZE:   size_in[2] = pwdata[SIZE_W-1:0];
            REG_POOL3_SIZE:   size_in[3] = pwdata[SIZE_W-1:0];
            REG_POOL_COUNTS:  counts_in  = pwdata[COUNTS_W-1:0];
            REG_MAX_REQUEST:  max_in     = pwdata[SIZE_W-1:0];
            default:          rebuild_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pools_ff   <= '0;
         size_ff    <= '0;
         counts_ff  <= '0;
         max_ff     <= MAX_REQUEST_RESET;
         rebuild_ff <= 1'b0;
      end else begin
         pools_ff   <= pools_in;
         size_ff    <= size_in;
         counts_ff  <= counts_in;
         max_ff     <= max_in;
         rebuild_ff <= rebuild_in;
      end
   end

   always_comb begin
      case (idx)
         REG_POOLS_IN_USE: prdata = CSR_DATA_W'(pools_ff);
         REG_POOL0_SIZE:   prdata = CSR_DATA_W'(size_ff[0]);
         REG_POOL1_SIZE:   prdata = CSR_DATA_W'(size_ff[1]);
         REG_POOL2_SIZE:   prdata = CSR_DATA_W'(size_ff[2]);
         REG_POOL3_SIZE:   prdata = CSR_DATA_W'(size_ff[3]);
         REG_POOL_COUNTS:  prdata = CSR_DATA_W'(counts_ff);
         REG_MAX_REQUEST:  prdata = CSR_DATA_W'(max_ff);
         default:          prdata = '0;
      endcase
   end

   assign np = (int'(pools_ff) > NUM_POOLS) ? NP_W'(NUM_POOLS) : NP_W'(pools_ff);

   for (genvar p = 0; p < NUM_POOLS; p++) begin : g_cap
      if (p < CFG_POOLS) begin : g_cfg
         logic [COUNT_FIELD_W-1:0] field;
         assign field   = counts_ff[COUNT_FIELD_W*p +: COUNT_FIELD_W];
         // clamp to the pool's storage
         assign caps[p] = (int'(field) > BUFS_PER_POOL) ? CNT_W'(BUFS_PER_POOL)
                                                        : CNT_W'(field);
      end else begin : g_none
         assign caps[p] = '0;
      end
   end

   assign pool_size   = size_ff;
   assign max_request = max_ff;
   assign rebuild     = rebuild_ff;

endmodule
